### design/lzmd_pkg.sv
// ----------------------------------------------------------------------------
// lzmd_pkg
// Shared constants, types and the match token decoder of the LZ marker token
// decompressor.
// ----------------------------------------------------------------------------
package lzmd_pkg;

  localparam int HISTORY_BYTES_DEF = 16384;
  localparam int CHUNK_BYTES_DEF   = 32;
  localparam int MAX_CHUNK         = 32;
  localparam int LANE_W            = 64;
  localparam int LANES             = 4;
  localparam int OUT_CNT_W         = 6;

  localparam int COUNT_W = 11;
  localparam int DIST_W  = 14;
  localparam int PROD_W  = 14;
  localparam logic [PROD_W-1:0] PRODUCED_MAX = 14'd16383;

  localparam logic [8:0]  FLAG_FETCH  = 9'h001;
  localparam logic [11:0] SHORT_BIAS  = 12'd32;
  localparam logic [COUNT_W-1:0] COUNT_BIAS = 11'd3;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [DIST_W-1:0]  reach;
  } match_t;

  // byte request from the engine to the chunk packer
  typedef struct packed {
    logic       vld;
    logic       has_byte;
    logic [7:0] data;
    logic       run_end;
    logic       strm_end;
    logic       trunc;
  } req_t;

  function automatic match_t decode_token(input logic [15:0] tok);
    match_t     m;
    logic [11:0] off;
    if (tok[15]) begin
      m.count = {1'b0, tok[14:5]} + COUNT_BIAS;
      off     = {7'd0, tok[4:0]};
    end else begin
      m.count = {7'd0, tok[14:11]} + COUNT_BIAS;
      off     = {1'b0, tok[10:0]} + SHORT_BIAS;
    end
    m.reach = {off + 12'd1, 2'b00};
    return m;
  endfunction

endpackage

### design/lzmd_ram.sv
// ----------------------------------------------------------------------------
// lzmd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lzmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/lzmd_engine.sv
// ----------------------------------------------------------------------------
// lzmd_engine
// Flag and token parser, match copy sequencer and history memory. Produces
// output bytes towards the chunk packer; during a match copy, one byte per cycle while the packer is ready.
// ----------------------------------------------------------------------------
module lzmd_engine #(
  parameter int HISTORY_BYTES = lzmd_pkg::HISTORY_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_first,
  input  logic           in_last,
  output lzmd_pkg::req_t req,
  input  logic           pk_ready
);
  import lzmd_pkg::*;

  localparam int AW = $clog2(HISTORY_BYTES);
  localparam int SW = ((AW > DIST_W) ? AW : DIST_W) + 1;
  localparam logic [AW-1:0] POS_LAST = AW'(HISTORY_BYTES - 1);
  localparam logic [SW-1:0] HIST_EXT = SW'(HISTORY_BYTES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_COPY = 1'b1;

  logic               state_r, state_nxt;
  logic [8:0]         flag_shift_r, flag_shift_nxt;
  logic               tok_pend_r, tok_pend_nxt;
  logic [7:0]         tok_high_r, tok_high_nxt;
  logic [AW-1:0]      wr_pos_r, wr_pos_nxt;
  logic [PROD_W-1:0]  produced_r, produced_nxt;
  logic [AW-1:0]      iss_pos_r, iss_pos_nxt;
  logic [PROD_W-1:0]  iss_prod_r, iss_prod_nxt;
  logic [COUNT_W-1:0] cp_left_r, cp_left_nxt;
  logic [DIST_W-1:0]  cp_dist_r, cp_dist_nxt;
  logic               run_last_r, run_last_nxt;

  logic               b_vld_r, b_vld_nxt;
  logic               b_has_r, b_has_nxt;
  logic               b_mem_r, b_mem_nxt;
  logic               b_zero_r, b_zero_nxt;
  logic [7:0]         b_lit_r, b_lit_nxt;
  logic               b_run_end_r, b_run_end_nxt;
  logic               b_strm_end_r, b_strm_end_nxt;
  logic               b_trunc_r, b_trunc_nxt;

  logic               acc, issue, b_fire, b_wr;
  logic [8:0]         fs;
  logic               tp;
  logic [AW-1:0]      wp;
  logic [PROD_W-1:0]  pr;
  match_t             mt;
  logic [SW-1:0]      pos_ext, dist_ext, src_ext;
  logic [AW-1:0]      raddr;
  logic [7:0]         rdata, b_data;

  assign in_ready = (state_r == ST_IDLE) && !b_vld_r;
  assign acc      = in_valid && in_ready;
  assign b_fire   = b_vld_r && pk_ready;
  assign b_wr     = b_fire && b_has_r;
  assign issue    = (state_r == ST_COPY) && (!b_vld_r || b_fire);

  assign fs = in_first ? FLAG_FETCH : flag_shift_r;
  assign tp = !in_first && tok_pend_r;
  assign wp = in_first ? '0 : wr_pos_r;
  assign pr = in_first ? '0 : produced_r;
  assign mt = decode_token({tok_high_r, in_byte});

  // source address, wrapping below zero
  assign pos_ext  = SW'(iss_pos_r);
  assign dist_ext = SW'(cp_dist_r);
  assign src_ext  = (pos_ext >= dist_ext) ? (pos_ext - dist_ext)
                                          : (pos_ext + HIST_EXT - dist_ext);
  assign raddr    = src_ext[AW-1:0];

  assign b_data = b_mem_r ? (b_zero_r ? 8'd0 : rdata) : b_lit_r;

  lzmd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_BYTES)
  ) u_hist (
    .clk   (clk),
    .we    (b_wr),
    .waddr (wr_pos_r),
    .wdata (b_data),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    flag_shift_nxt = flag_shift_r;
    tok_pend_nxt   = tok_pend_r;
    tok_high_nxt   = tok_high_r;
    wr_pos_nxt     = wr_pos_r;
    produced_nxt   = produced_r;
    iss_pos_nxt    = iss_pos_r;
    iss_prod_nxt   = iss_prod_r;
    cp_left_nxt    = cp_left_r;
    cp_dist_nxt    = cp_dist_r;
    run_last_nxt   = run_last_r;
    b_vld_nxt      = b_vld_r;
    b_has_nxt      = b_has_r;
    b_mem_nxt      = b_mem_r;
    b_zero_nxt     = b_zero_r;
    b_lit_nxt      = b_lit_r;
    b_run_end_nxt  = b_run_end_r;
    b_strm_end_nxt = b_strm_end_r;
    b_trunc_nxt    = b_trunc_r;

    if (b_fire) begin
      b_vld_nxt = 1'b0;
    end
    if (b_wr) begin
      wr_pos_nxt   = (wr_pos_r == POS_LAST) ? '0 : wr_pos_r + 1'b1;
      produced_nxt = (produced_r == PRODUCED_MAX) ? produced_r : produced_r + 1'b1;
    end

    if (acc) begin
      wr_pos_nxt     = wp;
      produced_nxt   = pr;
      flag_shift_nxt = fs;
      tok_pend_nxt   = 1'b0;
      b_has_nxt      = 1'b0;
      b_mem_nxt      = 1'b0;
      b_zero_nxt     = 1'b0;
      b_lit_nxt      = in_byte;
      b_run_end_nxt  = 1'b1;
      b_strm_end_nxt = in_last;
      b_trunc_nxt    = 1'b0;
      if (tp) begin
        // second token byte: start the match copy
        flag_shift_nxt = fs >> 1;
        cp_left_nxt    = mt.count;
        cp_dist_nxt    = mt.reach;
        iss_pos_nxt    = wp;
        iss_prod_nxt   = pr;
        run_last_nxt   = in_last;
        state_nxt      = ST_COPY;
      end else if (fs[8:1] == 8'd0) begin
        flag_shift_nxt = {1'b1, in_byte};
        b_vld_nxt      = in_last;
      end else if (fs[0]) begin
        tok_high_nxt = in_byte;
        if (in_last) begin
          flag_shift_nxt = fs >> 1;
          b_trunc_nxt    = 1'b1;
          b_vld_nxt      = 1'b1;
        end else begin
          tok_pend_nxt = 1'b1;
        end
      end else begin
        flag_shift_nxt = fs >> 1;
        b_has_nxt      = 1'b1;
        b_vld_nxt      = 1'b1;
      end
    end

    if (issue) begin
      b_vld_nxt      = 1'b1;
      b_has_nxt      = 1'b1;
      b_mem_nxt      = 1'b1;
      b_zero_nxt     = cp_dist_r > iss_prod_r;
      b_run_end_nxt  = cp_left_r == COUNT_W'(1);
      b_strm_end_nxt = run_last_r;
      b_trunc_nxt    = 1'b0;
      iss_pos_nxt    = (iss_pos_r == POS_LAST) ? '0 : iss_pos_r + 1'b1;
      iss_prod_nxt   = (iss_prod_r == PRODUCED_MAX) ? iss_prod_r : iss_prod_r + 1'b1;
      cp_left_nxt    = cp_left_r - 1'b1;
      if (cp_left_r == COUNT_W'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      flag_shift_r <= FLAG_FETCH;
      tok_pend_r   <= 1'b0;
      tok_high_r   <= 8'd0;
      wr_pos_r     <= '0;
      produced_r   <= '0;
      iss_pos_r    <= '0;
      iss_prod_r   <= '0;
      cp_left_r    <= '0;
      run_last_r   <= 1'b0;
      b_vld_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flag_shift_r <= flag_shift_nxt;
      tok_pend_r   <= tok_pend_nxt;
      tok_high_r   <= tok_high_nxt;
      wr_pos_r     <= wr_pos_nxt;
      produced_r   <= produced_nxt;
      iss_pos_r    <= iss_pos_nxt;
      iss_prod_r   <= iss_prod_nxt;
      cp_left_r    <= cp_left_nxt;
      run_last_r   <= run_last_nxt;
      b_vld_r      <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_dist_r    <= cp_dist_nxt;
    b_has_r      <= b_has_nxt;
    b_mem_r      <= b_mem_nxt;
    b_zero_r     <= b_zero_nxt;
    b_lit_r      <= b_lit_nxt;
    b_run_end_r  <= b_run_end_nxt;
    b_strm_end_r <= b_strm_end_nxt;
    b_trunc_r    <= b_trunc_nxt;
  end

  assign req.vld      = b_vld_r;
  assign req.has_byte = b_has_r;
  assign req.data     = b_data;
  assign req.run_end  = b_run_end_r;
  assign req.strm_end = b_strm_end_r;
  assign req.trunc    = b_trunc_r;

endmodule

### design/lzmd_packer.sv
// ----------------------------------------------------------------------------
// lzmd_packer
// Gathers output bytes into chunks and holds the finished chunk in the
// output register.
// ----------------------------------------------------------------------------
module lzmd_packer #(
  parameter int CHUNK_BYTES = lzmd_pkg::CHUNK_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lzmd_pkg::req_t                     req,
  output logic                               pk_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lzmd_pkg::LANES-1:0][lzmd_pkg::LANE_W-1:0] out_lanes,
  output logic [lzmd_pkg::OUT_CNT_W-1:0]     out_byte_count,
  output logic                               out_last_of_run,
  output logic                               out_stream_end,
  output logic                               out_truncated
);
  import lzmd_pkg::*;

  localparam int CW = $clog2(CHUNK_BYTES);
  localparam int NW = $clog2(CHUNK_BYTES + 1);

  logic [7:0]    asm_r [CHUNK_BYTES];
  logic [NW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic          closes, take;

  logic                             out_vld_r, out_vld_nxt;
  logic [LANES*LANE_W-1:0]          lanes_r, lanes_nxt;
  logic [OUT_CNT_W-1:0]             bcnt_r;
  logic                             run_end_r, strm_end_r, trunc_r;
  logic [7:0]                       chunk_byte [MAX_CHUNK];

  assign cnt_inc  = cnt_r + 1'b1;
  assign closes   = !req.has_byte || req.run_end || (cnt_inc == NW'(CHUNK_BYTES));
  assign pk_ready = !closes || !out_vld_r || out_ready;
  assign take     = req.vld && pk_ready;

  for (genvar k = 0; k < MAX_CHUNK; k++) begin : g_byte
    if (k < CHUNK_BYTES) begin : g_live
      assign chunk_byte[k] = !req.has_byte || (NW'(k) >= cnt_inc) ? 8'd0 :
                             (NW'(k) == cnt_r) ? req.data : asm_r[k];
    end else begin : g_zero
      assign chunk_byte[k] = 8'd0;
    end
    assign lanes_nxt[8*k +: 8] = chunk_byte[k];
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r;
    if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (take) begin
      cnt_nxt = closes ? '0 : cnt_inc;
      if (closes) begin
        out_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.has_byte) begin
      asm_r[cnt_r[CW-1:0]] <= req.data;
    end
    if (take && closes) begin
      lanes_r    <= lanes_nxt;
      bcnt_r     <= req.has_byte ? OUT_CNT_W'(cnt_inc) : '0;
      run_end_r  <= req.run_end;
      strm_end_r <= req.strm_end && req.run_end;
      trunc_r    <= req.trunc;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_lanes       = lanes_r;
  assign out_byte_count  = bcnt_r;
  assign out_last_of_run = run_end_r;
  assign out_stream_end  = strm_end_r;
  assign out_truncated   = trunc_r;

endmodule

### design/lz_marker_token_decompressor.sv
// ----------------------------------------------------------------------------
// lz_marker_token_decompressor
// Byte-serial LZ77 flag byte decompressor with chunked output.
// ----------------------------------------------------------------------------
// One compressed byte is taken per request. A flag byte or the first byte of
// a token gives no chunk; when it ends the stream one empty chunk follows. A
// literal is passed on as one byte, and no new byte is taken until the packer
// has accepted it. A token's second byte starts a match copy of count bytes
// (3 to 1026) that runs at one byte per cycle while the packer accepts bytes:
// the single, registered read port of the history memory sets that pace. Chunks
// of up to CHUNK_BYTES bytes leave through an output register; a chunk held by
// the downstream side stalls the copy only when the next chunk is complete.
// History starts unwritten and needs no clearing: bytes copied from before
// the start of the stream read as zero.
module lz_marker_token_decompressor #(
  parameter int HISTORY_BYTES = lzmd_pkg::HISTORY_BYTES_DEF,
  parameter int CHUNK_BYTES   = lzmd_pkg::CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_first_of_stream,
  input  logic        in_last_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_lane_a,
  output logic [63:0] out_lane_b,
  output logic [63:0] out_lane_c,
  output logic [63:0] out_lane_d,
  output logic [5:0]  out_byte_count,
  output logic        out_last_of_run,
  output logic        out_stream_end,
  output logic        out_truncated
);
  import lzmd_pkg::*;

  req_t                          req;
  logic                          pk_ready;
  logic [LANES-1:0][LANE_W-1:0]  lanes;

  lzmd_engine #(
    .HISTORY_BYTES (HISTORY_BYTES)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_first (in_first_of_stream),
    .in_last  (in_last_of_stream),
    .req      (req),
    .pk_ready (pk_ready)
  );

  lzmd_packer #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_packer (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .pk_ready        (pk_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_lanes       (lanes),
    .out_byte_count  (out_byte_count),
    .out_last_of_run (out_last_of_run),
    .out_stream_end  (out_stream_end),
    .out_truncated   (out_truncated)
  );

  assign out_lane_a = lanes[0];
  assign out_lane_b = lanes[1];
  assign out_lane_c = lanes[2];
  assign out_lane_d = lanes[3];

endmodule

### design/lzmd_checker.sv
// ----------------------------------------------------------------------------
// lzmd_checker
// Port level checks on the decompressor's chunk output, bound to the top.
// ----------------------------------------------------------------------------
module lzmd_checker #(
  parameter int CHUNK_BYTES = lzmd_pkg::CHUNK_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_lane_a,
  input logic [63:0] out_lane_b,
  input logic [63:0] out_lane_c,
  input logic [63:0] out_lane_d,
  input logic [5:0]  out_byte_count,
  input logic        out_last_of_run,
  input logic        out_stream_end,
  input logic        out_truncated
);
  import lzmd_pkg::*;

  localparam logic [OUT_CNT_W-1:0] CHUNK_CNT = OUT_CNT_W'(CHUNK_BYTES);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_count <= CHUNK_CNT)
    else $error("chunk byte count above chunk size");

  a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count != CHUNK_CNT |-> out_last_of_run)
    else $error("short chunk not marked as last of run");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count == 6'd0 |-> out_stream_end && out_last_of_run)
    else $error("empty chunk outside stream end");

  a_trunc_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_stream_end && out_byte_count == 6'd0)
    else $error("truncated flag on a non empty or non final chunk");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lane_a)
      && $stable(out_lane_b) && $stable(out_lane_c) && $stable(out_lane_d)
      && $stable(out_byte_count) && $stable(out_last_of_run)
      && $stable(out_stream_end) && $stable(out_truncated))
    else $error("stalled chunk changed");

endmodule

bind lz_marker_token_decompressor lzmd_checker #(
  .CHUNK_BYTES (CHUNK_BYTES)
) u_lzmd_checker (.*);
